[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the reaction step core.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// When the trigger holds, the condition must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, trig, cond)
`endif
`endif

[hw/rtl/gil_pkg.sv]
// Types, codes and constants of the reaction step core.
// Used by the front end, queue, divider, back end and top level.
`default_nettype none
package gil_pkg;

   localparam int LN_W = 38;
   localparam int DIV_W = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [59:0] PROP_CAP = '1;

   // Reaction indices as reported on the result channel.
   localparam logic [3:0] RX_HK_MAKE      = 4'd0;
   localparam logic [3:0] RX_HK_DECAY     = 4'd1;
   localparam logic [3:0] RX_HK_ACTIVATE  = 4'd2;
   localparam logic [3:0] RX_TRANSFER_RR  = 4'd3;
   localparam logic [3:0] RX_TRANSFER_SR  = 4'd4;
   localparam logic [3:0] RX_OUTPUT_MAKE  = 4'd5;
   localparam logic [3:0] RX_OUTPUT_DECAY = 4'd6;
   localparam logic [3:0] RX_HKP_DECAY    = 4'd7;
   localparam logic [3:0] NONE_FIRED      = 4'd8;

   // Configuration register indices.
   localparam logic [3:0] CSR_INDUCER_LEVEL     = 4'd0;
   localparam logic [3:0] CSR_HK_PRODUCTION     = 4'd1;
   localparam logic [3:0] CSR_DECAY_RATE        = 4'd2;
   localparam logic [3:0] CSR_MAX_ACTIVATION    = 4'd3;
   localparam logic [3:0] CSR_ACTIVATION_HALF   = 4'd4;
   localparam logic [3:0] CSR_TRANSFER_RATE_RR  = 4'd5;
   localparam logic [3:0] CSR_TRANSFER_RATE_SR  = 4'd6;
   localparam logic [3:0] CSR_MAX_OUTPUT_RATE   = 4'd7;

   typedef struct packed {
      logic [31:0] inducer_level;
      logic [31:0] hk_production_rate;
      logic [31:0] decay_rate;
      logic [31:0] max_activation_rate;
      logic [31:0] activation_half_level;
      logic [31:0] transfer_rate_rr;
      logic [31:0] transfer_rate_sr;
      logic [31:0] max_output_rate;
   } cfg_type;

   typedef struct packed {
      logic [LN_W-1:0] ln;
      logic [31:0]     uniform_pick;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [3:0]  fired_reaction;
      logic [63:0] elapsed_time;
      logic [15:0] count_hk;
      logic [15:0] count_hk_active;
      logic [15:0] count_rr_active;
      logic [15:0] count_sr_active;
      logic [15:0] count_output;
      logic        count_saturated;
   } result_type;

   typedef enum logic [2:0] {
      F_IDLE, F_NORM, F_SQ, F_LNA, F_LNB
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_MUL, B_ACC, B_KAP_DIV, B_PICK, B_TAU_DIV, B_FINISH
   } back_state_type;

   typedef enum logic [2:0] {
      OP_KAP_NUM, OP_DECAY_HK, OP_KAP_HK, OP_DECAY_OUT, OP_DECAY_HKP,
      OP_PICK_HI, OP_PICK_LO
   } mul_op_type;

endpackage
`default_nettype wire

[hw/rtl/gillespie_reaction_step_core.sv]
// One direct-method stochastic simulation step per request item. The front end
// works through up to 32 normalizing shifts, 32 squaring steps of the logarithm
// and the two ln scaling states F_LNA and F_LNB for an item, and passes it through a
// two-entry queue. The back end's work per item is set mainly by its shared
// 64-step restoring divider, which runs up to twice per item (activation rate
// and waiting time), plus seven multiplies and up to eight pick steps; an item
// with zero total propensity skips the waiting-time division. Results leave
// through an output register; a stalled response holds the back end in B_FINISH,
// then the queue and front end. Configuration writes are always accepted.
`default_nettype none
`include "assert_macros.svh"
module gillespie_reaction_step_core import gil_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // uniform_time [31:0], uniform_pick [63:32]
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_reaction [3:0], elapsed_time [67:4], count_hk [83:68],
   // count_hk_active [99:84], count_rr_active [115:100],
   // count_sr_active [131:116], count_output [147:132],
   // count_saturated [148], zero fill [151:149]
   output logic [151:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cfg_type      cfg_ff;
   logic         push_valid, push_ready, q_pop;
   q_entry_type  push_entry, q_head;
   q_status_type q_status;
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   result_type   rsp;
   logic         none_with_sat, silent_fired;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inducer_level         <= 32'd65536;
         cfg_ff.hk_production_rate    <= 32'd65536;
         cfg_ff.decay_rate            <= 32'd6554;
         cfg_ff.max_activation_rate   <= 32'd65536;
         cfg_ff.activation_half_level <= 32'd65536;
         cfg_ff.transfer_rate_rr      <= 32'd6554;
         cfg_ff.transfer_rate_sr      <= 32'd6554;
         cfg_ff.max_output_rate       <= 32'd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INDUCER_LEVEL:    cfg_ff.inducer_level         <= csr_data;
            CSR_HK_PRODUCTION:    cfg_ff.hk_production_rate    <= csr_data;
            CSR_DECAY_RATE:       cfg_ff.decay_rate            <= csr_data;
            CSR_MAX_ACTIVATION:   cfg_ff.max_activation_rate   <= csr_data;
            CSR_ACTIVATION_HALF:  cfg_ff.activation_half_level <= csr_data;
            CSR_TRANSFER_RATE_RR: cfg_ff.transfer_rate_rr      <= csr_data;
            CSR_TRANSFER_RATE_SR: cfg_ff.transfer_rate_sr      <= csr_data;
            CSR_MAX_OUTPUT_RATE:  cfg_ff.max_output_rate       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign push_ready = !q_status.full;

   gil_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .uniform_time (req_tdata[31:0]),
      .uniform_pick (req_tdata[63:32]),
      .push_valid   (push_valid),
      .push_entry   (push_entry),
      .push_ready   (push_ready)
   );

   gil_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   gil_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gil_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b0, rsp.count_saturated, rsp.count_output, rsp.count_sr_active,
                       rsp.count_rr_active, rsp.count_hk_active, rsp.count_hk,
                       rsp.elapsed_time, rsp.fired_reaction};

   assign none_with_sat = rsp_tvalid && (rsp.fired_reaction == NONE_FIRED)
                          && rsp.count_saturated;
   assign silent_fired  = rsp.fired_reaction inside {RX_TRANSFER_RR, RX_TRANSFER_SR,
                                                     RX_OUTPUT_MAKE};

   `ASSERT_ALWAYS(a_fired_range, clock, reset, !rsp_tvalid || rsp.fired_reaction <= NONE_FIRED)
   `ASSERT_ALWAYS(a_none_no_sat, clock, reset, !none_with_sat)
   `ASSERT_ALWAYS(a_silent_rx, clock, reset, !rsp_tvalid || !silent_fired)
   `ASSERT_NEXT(a_front_busy, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
`default_nettype wire

[hw/rtl/gil_front.sv]
// Front end: accepts an item and turns its time fraction into ln(1/u1) in Q6.32.
// Depends on gil_pkg; feeds gil_queue.
`default_nettype none
module gil_front import gil_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] uniform_time,
   input  logic [31:0] uniform_pick,
   output logic        push_valid,
   output q_entry_type push_entry,
   input  logic        push_ready
);

   front_state_type state_ff, state_in;
   logic [32:0]     x_ff, x_in;
   logic [5:0]      k_ff, k_in;
   logic [30:0]     m_ff, m_in;
   logic [31:0]     frac_ff, frac_in;
   logic [4:0]      iter_ff, iter_in;
   logic [31:0]     pick_ff, pick_in;
   logic [LN_W-1:0] ln_ff, ln_in;
   logic [63:0]     prod_ff, prod_in;
   logic [61:0]     sq;
   logic [31:0]     sq_sh;
   logic [37:0]     lval;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      iter_ff <= iter_in;
      pick_ff <= pick_in;
      ln_ff   <= ln_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (in_valid) state_in = F_NORM;
         F_NORM: if (x_ff[32]) state_in = F_SQ;
         F_SQ:   if (iter_ff == 5'd31) state_in = F_LNA;
         F_LNA:  state_in = F_LNB;
         F_LNB:  if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      k_in    = k_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      iter_in = iter_ff;
      pick_in = pick_ff;
      ln_in   = ln_ff;
      prod_in = prod_ff;
      sq      = {31'b0, m_ff} * {31'b0, m_ff};
      sq_sh   = sq[61:30];
      lval    = {k_ff, 32'b0} - {6'b0, frac_ff};
      in_ready   = (state_ff == F_IDLE);
      push_valid = (state_ff == F_LNB);
      push_entry.ln           = ln_ff + LN_W'(prod_ff[63:32]);
      push_entry.uniform_pick = pick_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               x_in    = {1'b0, uniform_time} + 33'd1;
               k_in    = '0;
               frac_in = '0;
               iter_in = '0;
               pick_in = uniform_pick;
            end
         end
         F_NORM: begin
            // Shift the leading one up to bit 32; -log2(u1) is the shift count minus
            // log2 of the normalized mantissa.
            if (x_ff[32]) begin
               m_in = x_ff[32:2];
            end else begin
               x_in = {x_ff[31:0], 1'b0};
               k_in = k_ff + 6'd1;
            end
         end
         F_SQ: begin
            // One fraction bit of log2 per squaring of the Q1.30 mantissa.
            m_in    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
            frac_in = {frac_ff[30:0], sq_sh[31]};
            iter_in = iter_ff + 5'd1;
         end
         F_LNA: begin
            ln_in   = LN_W'(lval[37:32]) * LN_W'(LN2_Q32);
            prod_in = {32'b0, lval[31:0]} * {32'b0, LN2_Q32};
         end
         F_LNB: begin
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/gil_queue.sv]
// Short queue of prepared items between the front end and the back end.
// Depends on gil_pkg.
`default_nettype none
module gil_queue import gil_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  q_entry_type  push_entry,
   input  logic         pop,
   output q_entry_type  head,
   output q_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   q_entry_type      store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   cnt_ff;
   logic             do_push, do_pop;

   assign status.full  = (cnt_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (do_push) begin
         store_ff[wr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/gil_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on gil_pkg.
`default_nettype none
module gil_divider import gil_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   trial, diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

[hw/rtl/gil_back.sv]
// Back end: propensities, waiting time, reaction choice and count update.
// Depends on gil_pkg; uses gil_divider through its request and response ports.
`default_nettype none
module gil_back import gil_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   input  q_entry_type  q_head,
   output logic         q_pop,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output result_type   rsp
);

   back_state_type state_ff, state_in;
   mul_op_type     op_ff, op_in;
   logic [63:0]    prod_ff, prod_in;
   logic [31:0]    kap_ff, kap_in;
   logic [59:0]    p1_ff, p1_in, p2_ff, p2_in, p6_ff, p6_in, p7_ff, p7_in;
   logic [62:0]    a0_ff, a0_in, tgt_ff, tgt_in, cum_ff, cum_in;
   logic [3:0]     pidx_ff, pidx_in, fired_ff, fired_in;
   logic [LN_W-1:0] ln_ff, ln_in;
   logic [31:0]    pick_ff, pick_in;
   logic [63:0]    tau_ff, tau_in;
   logic [63:0]    time_ff, time_in;
   logic [COUNT_WIDTH-1:0] hk_ff, hk_in, hka_ff, hka_in, out_ff, out_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff, rsp_in;

   logic [31:0]    mul_a, mul_b;
   logic [59:0]    prop_sat, prop_sel;
   logic [62:0]    a0_next, cum_next;
   logic [32:0]    den;
   logic           hit, out_free, sat_any;
   logic [64:0]    time_sum;
   logic [COUNT_WIDTH+31:0] hk_x, hka_x, out_x;

   assign hk_x     = {32'b0, hk_ff};
   assign hka_x    = {32'b0, hka_ff};
   assign out_x    = {32'b0, out_ff};
   assign prop_sat = (prod_ff > {4'b0, PROP_CAP}) ? PROP_CAP : prod_ff[59:0];
   assign a0_next  = a0_ff + {3'b0, prop_sat};
   assign den      = {1'b0, cfg.inducer_level} + {1'b0, cfg.activation_half_level};
   assign cum_next = cum_ff + {3'b0, prop_sel};
   assign hit      = (tgt_ff < cum_next);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign time_sum = {1'b0, time_ff} + {1'b0, tau_ff};

   // The RR and SR pools start empty and are never produced, so the two
   // transfer reactions and the Hill output term (RRp is zero) stay at zero.
   always_comb begin
      case (pidx_ff)
         RX_HK_MAKE:      prop_sel = {28'b0, cfg.hk_production_rate};
         RX_HK_DECAY:     prop_sel = p1_ff;
         RX_HK_ACTIVATE:  prop_sel = p2_ff;
         RX_OUTPUT_DECAY: prop_sel = p6_ff;
         RX_HKP_DECAY:    prop_sel = p7_ff;
         default:         prop_sel = '0;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_KAP_NUM:   begin mul_a = cfg.max_activation_rate; mul_b = cfg.inducer_level; end
         OP_DECAY_HK:  begin mul_a = cfg.decay_rate; mul_b = hk_x[31:0]; end
         OP_KAP_HK:    begin mul_a = kap_ff; mul_b = hk_x[31:0]; end
         OP_DECAY_OUT: begin mul_a = cfg.decay_rate; mul_b = out_x[31:0]; end
         OP_DECAY_HKP: begin mul_a = cfg.decay_rate; mul_b = hka_x[31:0]; end
         OP_PICK_HI:   begin mul_a = pick_ff; mul_b = {1'b0, a0_ff[62:32]}; end
         OP_PICK_LO:   begin mul_a = pick_ff; mul_b = a0_ff[31:0]; end
         default:      begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         hk_ff        <= '0;
         hka_ff       <= '0;
         out_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         hk_ff        <= hk_in;
         hka_ff       <= hka_in;
         out_ff       <= out_in;
      end
      op_ff   <= op_in;
      prod_ff <= prod_in;
      kap_ff  <= kap_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p6_ff   <= p6_in;
      p7_ff   <= p7_in;
      a0_ff   <= a0_in;
      tgt_ff  <= tgt_in;
      cum_ff  <= cum_in;
      pidx_ff <= pidx_in;
      fired_ff <= fired_in;
      ln_ff   <= ln_in;
      pick_ff <= pick_in;
      tau_ff  <= tau_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!q_status.empty) state_in = B_MUL;
         B_MUL:  state_in = B_ACC;
         B_ACC: begin
            unique case (op_ff)
               OP_KAP_NUM:   state_in = (den == '0) ? B_MUL : B_KAP_DIV;
               OP_DECAY_HKP: state_in = (a0_next == '0) ? B_FINISH : B_MUL;
               OP_PICK_LO:   state_in = B_PICK;
               default:      state_in = B_MUL;
            endcase
         end
         B_KAP_DIV: if (div_rsp.done) state_in = B_MUL;
         B_PICK:    if (hit) state_in = B_TAU_DIV;
         B_TAU_DIV: if (div_rsp.done) state_in = B_FINISH;
         B_FINISH:  if (out_free) state_in = B_IDLE;
         default:   state_in = B_IDLE;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      prod_in  = prod_ff;
      kap_in   = kap_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p6_in    = p6_ff;
      p7_in    = p7_ff;
      a0_in    = a0_ff;
      tgt_in   = tgt_ff;
      cum_in   = cum_ff;
      pidx_in  = pidx_ff;
      fired_in = fired_ff;
      ln_in    = ln_ff;
      pick_in  = pick_ff;
      tau_in   = tau_ff;
      time_in  = time_ff;
      hk_in    = hk_ff;
      hka_in   = hka_ff;
      out_in   = out_ff;
      rsp_in   = rsp_ff;
      sat_any  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = {31'b0, den};
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               q_pop   = 1'b1;
               ln_in   = q_head.ln;
               pick_in = q_head.uniform_pick;
               a0_in   = {31'b0, cfg.hk_production_rate};
               op_in   = OP_KAP_NUM;
            end
         end
         B_MUL: begin
            prod_in = {32'b0, mul_a} * {32'b0, mul_b};
         end
         B_ACC: begin
            unique case (op_ff)
               OP_KAP_NUM: begin
                  op_in = OP_DECAY_HK;
                  if (den == '0) begin
                     kap_in = '0;
                  end else begin
                     div_req.start = 1'b1;
                  end
               end
               OP_DECAY_HK:  begin p1_in = prop_sat; a0_in = a0_next; op_in = OP_KAP_HK; end
               OP_KAP_HK:    begin p2_in = prop_sat; a0_in = a0_next; op_in = OP_DECAY_OUT; end
               OP_DECAY_OUT: begin p6_in = prop_sat; a0_in = a0_next; op_in = OP_DECAY_HKP; end
               OP_DECAY_HKP: begin
                  p7_in    = prop_sat;
                  a0_in    = a0_next;
                  op_in    = OP_PICK_HI;
                  fired_in = NONE_FIRED;
               end
               OP_PICK_HI: begin
                  tgt_in = prod_ff[62:0];
                  op_in  = OP_PICK_LO;
               end
               OP_PICK_LO: begin
                  tgt_in  = tgt_ff + {31'b0, prod_ff[63:32]};
                  cum_in  = '0;
                  pidx_in = RX_HK_MAKE;
               end
               default: begin
               end
            endcase
         end
         B_KAP_DIV: begin
            if (div_rsp.done) kap_in = div_rsp.quotient[31:0];
         end
         B_PICK: begin
            // One cumulative add and compare per cycle; the first reaction
            // whose running sum passes the target fires.
            cum_in = cum_next;
            if (hit) begin
               fired_in         = pidx_ff;
               div_req.start    = 1'b1;
               div_req.dividend = {10'b0, ln_ff, 16'b0};
               div_req.divisor  = {1'b0, a0_ff};
            end else begin
               pidx_in = pidx_ff + 4'd1;
            end
         end
         B_TAU_DIV: begin
            if (div_rsp.done) tau_in = div_rsp.quotient;
         end
         B_FINISH: begin
            if (out_free) begin
               if (fired_ff != NONE_FIRED) begin
                  if (time_sum[64]) begin
                     time_in = '1;
                     sat_any = 1'b1;
                  end else begin
                     time_in = time_sum[63:0];
                  end
                  case (fired_ff) inside
                     RX_HK_MAKE: begin
                        if (hk_ff == '1) sat_any = 1'b1;
                        else hk_in = hk_ff + 1'b1;
                     end
                     RX_HK_DECAY: begin
                        if (hk_ff != '0) hk_in = hk_ff - 1'b1;
                     end
                     RX_HK_ACTIVATE: begin
                        if (hk_ff != '0) hk_in = hk_ff - 1'b1;
                        if (hka_ff == '1) sat_any = 1'b1;
                        else hka_in = hka_ff + 1'b1;
                     end
                     RX_OUTPUT_MAKE: begin
                        if (out_ff == '1) sat_any = 1'b1;
                        else out_in = out_ff + 1'b1;
                     end
                     RX_OUTPUT_DECAY: begin
                        if (out_ff != '0) out_in = out_ff - 1'b1;
                     end
                     RX_TRANSFER_RR, RX_TRANSFER_SR, RX_HKP_DECAY: begin
                        if (hka_ff != '0) hka_in = hka_ff - 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_valid_in           = 1'b1;
               rsp_in.fired_reaction  = fired_ff;
               rsp_in.elapsed_time    = time_in;
               rsp_in.count_hk        = 16'({32'b0, hk_in});
               rsp_in.count_hk_active = 16'({32'b0, hka_in});
               rsp_in.count_rr_active = '0;
               rsp_in.count_sr_active = '0;
               rsp_in.count_output    = 16'({32'b0, out_in});
               rsp_in.count_saturated = sat_any;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

[dv/tb_gillespie_reaction_step_core.sv]
// Self-checking testbench of the Gillespie reaction step core.
// Depends on gil_pkg and the core RTL; predicts every result item in its own model.
`default_nettype none
module tb_gillespie_reaction_step_core import gil_pkg::*;;

   localparam logic [63:0] CAPPED = {4'b0, PROP_CAP};

   typedef struct packed {
      logic [31:0] uniform_pick;
      logic [31:0] uniform_time;
   } step_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   gillespie_reaction_step_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predictor state: rate registers, species counts and simulated time.
   logic [63:0] rate_reg [8];
   logic [63:0] species [8];
   logic [63:0] sim_clock;

   step_item_type pending_steps [$];
   result_type    expected_results [$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_request = 0;
   int  fail_count = 0;
   int  checked_count = 0;
   int  fired_hist [9];
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] mul_capped(logic [63:0] a, logic [63:0] b);
      if (a == 0 || b == 0) return 0;
      if (b > CAPPED / a) return CAPPED;
      return a * b;
   endfunction

   // -log2((v+1)/2^32) in Q32.32, fraction bits by repeated squaring.
   function automatic logic [63:0] neg_log2(logic [63:0] v);
      logic [63:0] x, t, m, frac;
      int e;
      x = v + 1;
      t = x;
      e = 0;
      frac = 0;
      while (t > 1) begin
         t = t >> 1;
         e++;
      end
      m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'd32 << 32) - ((64'(e) << 32) | frac);
   endfunction

   function automatic void count_up(int idx, ref logic sat);
      if (species[idx] >= 64'hFFFF) begin
         species[idx] = 64'hFFFF;
         sat = 1'b1;
      end else begin
         species[idx]++;
      end
   endfunction

   function automatic void count_down(int idx);
      if (species[idx] > 0) species[idx]--;
   endfunction

   function automatic result_type predict_step(step_item_type it);
      logic [63:0] prop [8];
      logic [63:0] total, kap, den, sq, hill_q, lg, ln, tau, target, cum;
      logic [3:0]  fired;
      logic        sat;
      result_type  r;
      fired = NONE_FIRED;
      sat = 1'b0;
      den = rate_reg[CSR_INDUCER_LEVEL] + rate_reg[CSR_ACTIVATION_HALF];
      kap = (den != 0) ?
         (rate_reg[CSR_MAX_ACTIVATION] * rate_reg[CSR_INDUCER_LEVEL]) / den : 0;
      sq = species[3] * species[3] + 1;
      hill_q = rate_reg[CSR_MAX_OUTPUT_RATE] / sq;
      if (rate_reg[CSR_MAX_OUTPUT_RATE] % sq != 0) hill_q++;
      prop[0] = rate_reg[CSR_HK_PRODUCTION];
      prop[1] = mul_capped(rate_reg[CSR_DECAY_RATE], species[0]);
      prop[2] = mul_capped(kap, species[0]);
      prop[3] = mul_capped(mul_capped(rate_reg[CSR_TRANSFER_RATE_RR], species[1]), species[2]);
      prop[4] = mul_capped(mul_capped(rate_reg[CSR_TRANSFER_RATE_SR], species[1]), species[4]);
      prop[5] = rate_reg[CSR_MAX_OUTPUT_RATE] - hill_q;
      prop[6] = mul_capped(rate_reg[CSR_DECAY_RATE], species[7]);
      prop[7] = mul_capped(rate_reg[CSR_DECAY_RATE], species[1]);
      total = 0;
      for (int i = 0; i < 8; i++) total += prop[i];
      if (total != 0) begin
         lg = neg_log2(64'(it.uniform_time));
         ln = (lg >> 32) * LN2_Q32 + (((lg & 64'hFFFF_FFFF) * LN2_Q32) >> 32);
         tau = (ln << 16) / total;
         target = 64'(it.uniform_pick) * (total >> 32) +
                  ((64'(it.uniform_pick) * (total & 64'hFFFF_FFFF)) >> 32);
         if (sim_clock > ~64'd0 - tau) begin
            sim_clock = ~64'd0;
            sat = 1'b1;
         end else begin
            sim_clock += tau;
         end
         cum = 0;
         for (int i = 0; i < 8; i++) begin
            cum += prop[i];
            if (target < cum && fired == NONE_FIRED) fired = 4'(i);
         end
         case (fired)
            RX_HK_MAKE:      count_up(0, sat);
            RX_HK_DECAY:     count_down(0);
            RX_HK_ACTIVATE:  begin count_down(0); count_up(1, sat); end
            RX_TRANSFER_RR:  begin count_down(1); count_up(3, sat); end
            RX_TRANSFER_SR:  begin count_down(1); count_up(5, sat); end
            RX_OUTPUT_MAKE:  count_up(7, sat);
            RX_OUTPUT_DECAY: count_down(7);
            RX_HKP_DECAY:    count_down(1);
            default: ;
         endcase
      end
      r.fired_reaction  = fired;
      r.elapsed_time    = sim_clock;
      r.count_hk        = species[0][15:0];
      r.count_hk_active = species[1][15:0];
      r.count_rr_active = species[3][15:0];
      r.count_sr_active = species[5][15:0];
      r.count_output    = species[7][15:0];
      r.count_saturated = sat;
      return r;
   endfunction

   // Request driver: holds an offered item until it is taken.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= pending_steps.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready, with an optional long hold-off counted here.
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      req_fire = req_tvalid && req_tready && !reset;
      rsp_fire = rsp_tvalid && rsp_tready && !reset;
      if (csr_valid && csr_ready && !reset && csr_index < 8)
         rate_reg[csr_index] = 64'(csr_data);
      if (req_fire) expected_results.push_back(predict_step(req_tdata));
      if (rsp_fire) begin
         got.fired_reaction  = rsp_tdata[3:0];
         got.elapsed_time    = rsp_tdata[67:4];
         got.count_hk        = rsp_tdata[83:68];
         got.count_hk_active = rsp_tdata[99:84];
         got.count_rr_active = rsp_tdata[115:100];
         got.count_sr_active = rsp_tdata[131:116];
         got.count_output    = rsp_tdata[147:132];
         got.count_saturated = rsp_tdata[148];
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            fired_hist[want.fired_reaction]++;
            if (got.fired_reaction != want.fired_reaction) begin
               $error("fired_reaction exp %0d got %0d", want.fired_reaction,
                      got.fired_reaction);
               fail_count++;
            end
            if (got.elapsed_time != want.elapsed_time) begin
               $error("elapsed_time exp %h got %h", want.elapsed_time, got.elapsed_time);
               fail_count++;
            end
            if (got.count_hk != want.count_hk) begin
               $error("count_hk exp %0d got %0d", want.count_hk, got.count_hk);
               fail_count++;
            end
            if (got.count_hk_active != want.count_hk_active) begin
               $error("count_hk_active exp %0d got %0d", want.count_hk_active,
                      got.count_hk_active);
               fail_count++;
            end
            if (got.count_rr_active != want.count_rr_active) begin
               $error("count_rr_active exp %0d got %0d", want.count_rr_active,
                      got.count_rr_active);
               fail_count++;
            end
            if (got.count_sr_active != want.count_sr_active) begin
               $error("count_sr_active exp %0d got %0d", want.count_sr_active,
                      got.count_sr_active);
               fail_count++;
            end
            if (got.count_output != want.count_output) begin
               $error("count_output exp %0d got %0d", want.count_output, got.count_output);
               fail_count++;
            end
            if (got.count_saturated != want.count_saturated) begin
               $error("count_saturated exp %0d got %0d", want.count_saturated,
                      got.count_saturated);
               fail_count++;
            end
         end
      end
   end

   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_steps.size() > 0 || expected_results.size() > 0 || req_tvalid);
   endtask

   task automatic write_rate(logic [3:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rate settings: 0 defaults, 1 no production, 2 all maximum, 3 all zero but
   // production and activation half level, 4 small random, 5 random full range, 6 no inducer.
   task automatic load_rates(int mode);
      logic [31:0] v [8];
      v = '{32'd65536, 32'd65536, 32'd6554, 32'd65536, 32'd65536, 32'd6554,
            32'd6554, 32'd65536};
      case (mode)
         1: v[CSR_HK_PRODUCTION] = 0;
         2: foreach (v[i]) v[i] = '1;
         3: begin
            foreach (v[i]) v[i] = 0;
            v[CSR_HK_PRODUCTION] = 1;
            v[CSR_ACTIVATION_HALF] = 1;
         end
         4: foreach (v[i]) v[i] = $urandom_range(1, 300000);
         5: foreach (v[i]) v[i] = $urandom;
         6: v[CSR_INDUCER_LEVEL] = 0;
         default: ;
      endcase
      if (v[CSR_ACTIVATION_HALF] == 0) v[CSR_ACTIVATION_HALF] = 1;
      for (int i = 0; i < 8; i++) write_rate(4'(i), v[i]);
   endtask

   task automatic push_step(logic [31:0] ut, logic [31:0] up);
      step_item_type it;
      it.uniform_time = ut;
      it.uniform_pick = up;
      pending_steps.push_back(it);
   endtask

   initial begin
      int modes [6] = '{0, 4, 2, 5, 6, 3};
      int idle_send [4] = '{0, 46, 0, 13};
      int idle_recv [4] = '{0, 0, 46, 13};
      rate_reg = '{64'd65536, 64'd65536, 64'd6554, 64'd65536, 64'd65536, 64'd6554,
                   64'd6554, 64'd65536};
      foreach (species[i]) species[i] = 0;
      sim_clock = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Nothing can fire with zero production and empty counts.
      load_rates(1);
      push_step(0, 0);
      push_step('1, '1);
      wait_quiet();

      load_rates(0);
      push_step(0, 0);
      push_step('1, '1);
      push_step(0, '1);
      push_step('1, 0);
      push_step(32'h8000_0000, 32'h8000_0000);
      push_step(1, 32'h7FFF_FFFF);
      for (int i = 0; i < 14; i++) push_step($urandom, $urandom);
      wait_quiet();

      for (int ph = 0; ph < 12; ph++) begin
         load_rates(modes[ph % 6]);
         send_idle_pct = idle_send[ph % 4];
         recv_stall_pct = idle_recv[ph % 4];
         for (int i = 0; i < 115; i++) begin
            case ($urandom_range(9))
               0: push_step('1, $urandom);
               1: push_step($urandom_range(0, 255), $urandom);
               2: push_step($urandom, $urandom_range(0, 255));
               default: push_step($urandom, $urandom);
            endcase
         end
         if (ph == 4) begin
            // Long response stall while items keep coming in.
            @(negedge clock);
            hold_request = 2000;
         end
         wait_quiet();
         if (ph == 5) begin
            load_rates(0);
            // Drain accumulated counts toward the defaults.
         end
      end

      repeat (400) @(posedge clock);
      $display("checked %0d step results; fired counts by reaction 0..8: %p",
               checked_count, fired_hist);
      $display("rate settings covered defaults, zero, maximum, random and no inducer");
      if (fail_count == 0) begin
         $display("tb_gillespie_reaction_step_core OK");
      end else begin
         $display("tb_gillespie_reaction_step_core NOT OK");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("tb_gillespie_reaction_step_core NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

[gillespie_reaction_step_core.f]
+incdir+hw/rtl
hw/rtl/gil_pkg.sv
hw/rtl/gil_front.sv
hw/rtl/gil_queue.sv
hw/rtl/gil_divider.sv
hw/rtl/gil_back.sv
hw/rtl/gillespie_reaction_step_core.sv
dv/tb_gillespie_reaction_step_core.sv
